FILE: rtl/fbik_pkg.sv
`timescale 1ns / 1ps
// Shared widths, config struct, CORDIC arctangent table and angle helpers
// for the five-bar leg inverse kinematics block. No dependencies.
package fbik_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int LEN_W  = 13;
	localparam int POS_W  = 14;
	localparam int OUT_W  = 16;
	localparam int PW     = 30;
	localparam int SW     = 31;
	localparam int DW     = 2 * SW;
	localparam int RAD_W  = 58;
	localparam int ROOT_W = RAD_W / 2;
	localparam int ISQ_N  = ROOT_W;
	localparam int MW     = SW + 1;
	localparam int NW     = SW + 2;
	localparam int CW     = NW + 3;
	localparam int NORM_N = 5;
	localparam int NORM_TOP = 30;
	localparam int ZW     = ANGLE_BITS + 1;
	localparam int AW     = ANGLE_BITS + 3;
	localparam int TW     = AW + OUT_W + 1;
	localparam int ATAN_SH = 32 - ANGLE_BITS;
	localparam int OUT_SH  = ANGLE_BITS - OUT_W;

	localparam int FRONT_N    = 5;
	localparam int CORDIC_LAT = 1 + NORM_N + CORDIC_STEPS;
	localparam int LEG_LAT    = FRONT_N + ISQ_N + 1 + CORDIC_LAT + 1;
	localparam int TOP_LAT    = LEG_LAT + 1;

	localparam logic signed [AW-1:0] ANG_FULL    = AW'(2 ** ANGLE_BITS);
	localparam logic signed [AW-1:0] ANG_QUARTER = AW'(2 ** (ANGLE_BITS - 2));

	localparam logic [31:0] ATAN_TURNS32 [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [LEN_W-1:0] crank_one_length;
		logic [LEN_W-1:0] rod_one_length;
		logic [LEN_W-1:0] rod_two_length;
		logic [LEN_W-1:0] crank_two_length;
		logic [LEN_W-1:0] motor_spacing;
		logic [LEN_W-1:0] min_height;
		logic [LEN_W-1:0] max_height;
	} cfg_t;

	typedef struct packed {
		logic signed [SW-1:0] b;
		logic signed [SW-1:0] e;
		logic signed [SW-1:0] ac;
		logic signed [SW-1:0] df;
		logic                 unr;
	} side_t;

	function automatic logic signed [ZW-1:0] cordic_step(input int i);
		logic [63:0] t;
		t = (64'(ATAN_TURNS32[i]) + (64'd1 << (ATAN_SH - 1))) >> ATAN_SH;
		return $signed(t[ZW-1:0]);
	endfunction

	function automatic logic [OUT_W-1:0] to_out16(input logic signed [AW-1:0] v);
		logic signed [TW-1:0] t;
		t = TW'(v);
		if (OUT_SH > 0) begin
			t = (t + TW'(2 ** (OUT_SH - 1))) >>> OUT_SH;
		end else if (OUT_SH < 0) begin
			t = t <<< (-OUT_SH);
		end
		return t[OUT_W-1:0];
	endfunction

endpackage

FILE: rtl/fbik_isqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root, one root bit per stage.
// Depends on fbik_pkg.
module fbik_isqrt import fbik_pkg::*; (
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rad_s  [1:ISQ_N-1];
	logic [ROOT_W+2:0] rem_s  [1:ISQ_N-1];
	logic [ROOT_W-1:0] root_s [1:ISQ_N];

	logic [RAD_W-1:0]  cur_rad  [0:ISQ_N-1];
	logic [ROOT_W+2:0] cur_rem  [0:ISQ_N-1];
	logic [ROOT_W-1:0] cur_root [0:ISQ_N-1];
	logic [ROOT_W+2:0] cand     [0:ISQ_N-1];
	logic [ROOT_W+2:0] trial    [0:ISQ_N-1];
	logic              take     [0:ISQ_N-1];

	genvar k;
	generate
		for (k = 0; k < ISQ_N; k++) begin : g_stage
			if (k == 0) begin : g_in
				assign cur_rad[k]  = rad;
				assign cur_rem[k]  = '0;
				assign cur_root[k] = '0;
			end else begin : g_mid
				assign cur_rad[k]  = rad_s[k];
				assign cur_rem[k]  = rem_s[k];
				assign cur_root[k] = root_s[k];
			end

			assign cand[k]  = {cur_rem[k][ROOT_W:0], cur_rad[k][RAD_W-1 -: 2]};
			assign trial[k] = {1'b0, cur_root[k], 2'b01};
			assign take[k]  = (cand[k] >= trial[k]);

			always_ff @(posedge clk) begin
				root_s[k+1] <= {cur_root[k][ROOT_W-2:0], take[k]};
			end

			if (k < ISQ_N - 1) begin : g_rem
				always_ff @(posedge clk) begin
					rad_s[k+1] <= cur_rad[k] << 2;
					rem_s[k+1] <= take[k] ? (cand[k] - trial[k]) : cand[k];
				end
			end
		end
	endgenerate

	assign root = root_s[ISQ_N];

endmodule

FILE: rtl/fbik_cordic.sv
`timescale 1ns / 1ps
// Pipelined arctangent: sign fold, staged normalizing shift, CORDIC vectoring.
// Depends on fbik_pkg.
module fbik_cordic import fbik_pkg::*; (
	input  logic                 clk,
	input  logic signed [SW-1:0] num,
	input  logic signed [SW-1:0] den,
	output logic signed [ZW-1:0] z
);

	logic signed [NW-1:0] x_in, y_in;
	logic [MW-1:0]        ay_in;

	logic signed [NW-1:0] px_s1, py_s1;
	logic [MW-1:0]        pm_s1;
	logic                 pz_s1;

	always_comb begin
		if (den < 0) begin
			x_in = -NW'(den);
			y_in = -NW'(num);
		end else begin
			x_in = NW'(den);
			y_in = NW'(num);
		end
		ay_in = (y_in < 0) ? MW'(-y_in) : MW'(y_in);
	end

	always_ff @(posedge clk) begin
		px_s1 <= x_in;
		py_s1 <= y_in;
		pm_s1 <= (MW'(x_in) > ay_in) ? MW'(x_in) : ay_in;
		pz_s1 <= (x_in == '0) && (y_in == '0);
	end

	// normalize: binary search on the left shift
	logic signed [NW-1:0] nx_s [1:NORM_N];
	logic signed [NW-1:0] ny_s [1:NORM_N];
	logic [MW-1:0]        nm_s [1:NORM_N];
	logic                 nz_s [1:NORM_N];

	logic signed [NW-1:0] nx_c [0:NORM_N-1];
	logic signed [NW-1:0] ny_c [0:NORM_N-1];
	logic [MW-1:0]        nm_c [0:NORM_N-1];
	logic                 nz_c [0:NORM_N-1];

	genvar j;
	generate
		for (j = 0; j < NORM_N; j++) begin : g_norm
			localparam int SH = (1 << (NORM_N - 1)) >> j;
			if (j == 0) begin : g_in
				assign nx_c[j] = px_s1;
				assign ny_c[j] = py_s1;
				assign nm_c[j] = pm_s1;
				assign nz_c[j] = pz_s1;
			end else begin : g_mid
				assign nx_c[j] = nx_s[j];
				assign ny_c[j] = ny_s[j];
				assign nm_c[j] = nm_s[j];
				assign nz_c[j] = nz_s[j];
			end
			always_ff @(posedge clk) begin
				nz_s[j+1] <= nz_c[j];
				if (nm_c[j] < (MW'(1) << (NORM_TOP + 1 - SH))) begin
					nx_s[j+1] <= nx_c[j] <<< SH;
					ny_s[j+1] <= ny_c[j] <<< SH;
					nm_s[j+1] <= nm_c[j] << SH;
				end else begin
					nx_s[j+1] <= nx_c[j];
					ny_s[j+1] <= ny_c[j];
					nm_s[j+1] <= nm_c[j];
				end
			end
		end
	endgenerate

	// vectoring iterations
	logic signed [CW-1:0] cx_s  [1:CORDIC_STEPS];
	logic signed [CW-1:0] cy_s  [1:CORDIC_STEPS];
	logic signed [ZW-1:0] cz_s  [1:CORDIC_STEPS];
	logic                 cf_s  [1:CORDIC_STEPS];

	logic signed [CW-1:0] cx_c  [0:CORDIC_STEPS-1];
	logic signed [CW-1:0] cy_c  [0:CORDIC_STEPS-1];
	logic signed [ZW-1:0] cz_c  [0:CORDIC_STEPS-1];
	logic                 cf_c  [0:CORDIC_STEPS-1];
	logic signed [CW-1:0] xs_c  [0:CORDIC_STEPS-1];
	logic signed [CW-1:0] ys_c  [0:CORDIC_STEPS-1];

	genvar i;
	generate
		for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
			localparam logic signed [ZW-1:0] STEP = cordic_step(i);
			if (i == 0) begin : g_in
				assign cx_c[i] = CW'(nx_s[NORM_N]);
				assign cy_c[i] = CW'(ny_s[NORM_N]);
				assign cz_c[i] = '0;
				assign cf_c[i] = nz_s[NORM_N];
			end else begin : g_mid
				assign cx_c[i] = cx_s[i];
				assign cy_c[i] = cy_s[i];
				assign cz_c[i] = cz_s[i];
				assign cf_c[i] = cf_s[i];
			end
			assign xs_c[i] = cx_c[i] >>> i;
			assign ys_c[i] = cy_c[i] >>> i;
			always_ff @(posedge clk) begin
				cf_s[i+1] <= cf_c[i];
				if (!cy_c[i][CW-1]) begin
					cx_s[i+1] <= cx_c[i] + ys_c[i];
					cy_s[i+1] <= cy_c[i] - xs_c[i];
					cz_s[i+1] <= cz_c[i] + STEP;
				end else begin
					cx_s[i+1] <= cx_c[i] - ys_c[i];
					cy_s[i+1] <= cy_c[i] + xs_c[i];
					cz_s[i+1] <= cz_c[i] - STEP;
				end
			end
		end
	endgenerate

	assign z = cf_s[CORDIC_STEPS] ? '0 : cz_s[CORDIC_STEPS];

endmodule

FILE: rtl/fbik_leg.sv
`timescale 1ns / 1ps
// One leg lane: clamp, linkage coefficients, discriminants, two square roots,
// four arctangents and candidate selection. Depends on fbik_pkg,
// fbik_isqrt and fbik_cordic.
module fbik_leg import fbik_pkg::*; (
	input  logic                    clk,
	input  logic signed [POS_W-1:0] x,
	input  logic signed [POS_W-1:0] y,
	input  cfg_t                    cfg,
	output logic [OUT_W-1:0]        alpha,
	output logic signed [OUT_W-1:0] beta,
	output logic                    unr
);

	logic signed [POS_W-1:0] l1, l2, l3, l4, l5, hmin, hmax, yc;

	assign l1   = $signed({1'b0, cfg.crank_one_length});
	assign l2   = $signed({1'b0, cfg.rod_one_length});
	assign l3   = $signed({1'b0, cfg.rod_two_length});
	assign l4   = $signed({1'b0, cfg.crank_two_length});
	assign l5   = $signed({1'b0, cfg.motor_spacing});
	assign hmin = $signed({1'b0, cfg.min_height});
	assign hmax = $signed({1'b0, cfg.max_height});

	always_comb begin
		if (y > hmax) begin
			yc = hmax;
		end else if (y < hmin) begin
			yc = hmin;
		end else begin
			yc = y;
		end
	end

	logic signed [POS_W-1:0] x_s1, y_s1;
	logic signed [POS_W:0]   u_s1;

	always_ff @(posedge clk) begin
		x_s1 <= x;
		y_s1 <= yc;
		u_s1 <= (POS_W+1)'(x) - (POS_W+1)'(l5);
	end

	logic signed [PW-1:0] xl1_s2, yl1_s2, xx_s2, yy_s2, l1l1_s2, l2l2_s2;
	logic signed [PW-1:0] ul4_s2, yl4_s2, uu_s2, l4l4_s2, l3l3_s2;

	always_ff @(posedge clk) begin
		xl1_s2  <= PW'(x_s1) * PW'(l1);
		yl1_s2  <= PW'(y_s1) * PW'(l1);
		xx_s2   <= PW'(x_s1) * PW'(x_s1);
		yy_s2   <= PW'(y_s1) * PW'(y_s1);
		l1l1_s2 <= PW'(l1) * PW'(l1);
		l2l2_s2 <= PW'(l2) * PW'(l2);
		ul4_s2  <= PW'(u_s1) * PW'(l4);
		yl4_s2  <= PW'(y_s1) * PW'(l4);
		uu_s2   <= PW'(u_s1) * PW'(u_s1);
		l4l4_s2 <= PW'(l4) * PW'(l4);
		l3l3_s2 <= PW'(l3) * PW'(l3);
	end

	logic signed [SW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3, f_s3;

	always_ff @(posedge clk) begin
		a_s3 <= SW'(xl1_s2) <<< 1;
		b_s3 <= SW'(yl1_s2) <<< 1;
		c_s3 <= SW'(xx_s2) + SW'(yy_s2) + SW'(l1l1_s2) - SW'(l2l2_s2);
		d_s3 <= SW'(ul4_s2) <<< 1;
		e_s3 <= SW'(yl4_s2) <<< 1;
		f_s3 <= SW'(uu_s2) + SW'(l4l4_s2) + SW'(yy_s2) - SW'(l3l3_s2);
	end

	logic signed [DW-1:0] aa_s4, bb_s4, cc_s4, dd_s4, ee_s4, ff_s4;
	logic signed [SW-1:0] b_s4, e_s4, ac_s4, df_s4;

	always_ff @(posedge clk) begin
		aa_s4 <= a_s3 * a_s3;
		bb_s4 <= b_s3 * b_s3;
		cc_s4 <= c_s3 * c_s3;
		dd_s4 <= d_s3 * d_s3;
		ee_s4 <= e_s3 * e_s3;
		ff_s4 <= f_s3 * f_s3;
		b_s4  <= b_s3;
		e_s4  <= e_s3;
		ac_s4 <= a_s3 + c_s3;
		df_s4 <= d_s3 + f_s3;
	end

	logic signed [DW-1:0] disc1, disc2;
	logic [RAD_W-1:0]     rad1_s5, rad2_s5;
	side_t                side_s5;

	assign disc1 = aa_s4 + bb_s4 - cc_s4;
	assign disc2 = dd_s4 + ee_s4 - ff_s4;

	always_ff @(posedge clk) begin
		rad1_s5     <= disc1[DW-1] ? '0 : disc1[RAD_W-1:0];
		rad2_s5     <= disc2[DW-1] ? '0 : disc2[RAD_W-1:0];
		side_s5.b   <= b_s4;
		side_s5.e   <= e_s4;
		side_s5.ac  <= ac_s4;
		side_s5.df  <= df_s4;
		side_s5.unr <= disc1[DW-1] || disc2[DW-1];
	end

	logic [ROOT_W-1:0] root1, root2;

	fbik_isqrt u_sqrt_a (.clk(clk), .rad(rad1_s5), .root(root1));
	fbik_isqrt u_sqrt_b (.clk(clk), .rad(rad2_s5), .root(root2));

	side_t side_q [0:ISQ_N-1];

	always_ff @(posedge clk) begin
		side_q[0] <= side_s5;
		for (int k = 1; k < ISQ_N; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	logic signed [SW-1:0] r1, r2;
	logic signed [SW-1:0] n1_s6, n2_s6, n3_s6, n4_s6, den1_s6, den2_s6;
	logic                 unr_s6;

	assign r1 = $signed(SW'(root1));
	assign r2 = $signed(SW'(root2));

	always_ff @(posedge clk) begin
		n1_s6   <= side_q[ISQ_N-1].b + r1;
		n2_s6   <= side_q[ISQ_N-1].b - r1;
		n3_s6   <= side_q[ISQ_N-1].e + r2;
		n4_s6   <= side_q[ISQ_N-1].e - r2;
		den1_s6 <= side_q[ISQ_N-1].ac;
		den2_s6 <= side_q[ISQ_N-1].df;
		unr_s6  <= side_q[ISQ_N-1].unr;
	end

	logic signed [ZW-1:0] za1, za2, zb1, zb2;

	fbik_cordic u_atan_a1 (.clk(clk), .num(n1_s6), .den(den1_s6), .z(za1));
	fbik_cordic u_atan_a2 (.clk(clk), .num(n2_s6), .den(den1_s6), .z(za2));
	fbik_cordic u_atan_b1 (.clk(clk), .num(n3_s6), .den(den2_s6), .z(zb1));
	fbik_cordic u_atan_b2 (.clk(clk), .num(n4_s6), .den(den2_s6), .z(zb2));

	logic unr_q [0:CORDIC_LAT-1];

	always_ff @(posedge clk) begin
		unr_q[0] <= unr_s6;
		for (int k = 1; k < CORDIC_LAT; k++) begin
			unr_q[k] <= unr_q[k-1];
		end
	end

	logic signed [AW-1:0] a1, a2, al, b1, b2, be;

	always_comb begin
		a1 = AW'(za1) <<< 1;
		a2 = AW'(za2) <<< 1;
		if (a1 < 0) begin
			a1 = a1 + ANG_FULL;
		end
		if (a2 < 0) begin
			a2 = a2 + ANG_FULL;
		end
		al = (a1 >= ANG_QUARTER) ? a1 : a2;
		b1 = AW'(zb1) <<< 1;
		b2 = AW'(zb2) <<< 1;
		be = (b1 >= 0 && b1 <= ANG_QUARTER) ? b1 : b2;
	end

	logic [OUT_W-1:0] alpha_s7, beta_s7;
	logic             unr_s7;

	always_ff @(posedge clk) begin
		alpha_s7 <= unr_q[CORDIC_LAT-1] ? '0 : to_out16(al);
		beta_s7  <= unr_q[CORDIC_LAT-1] ? '0 : to_out16(be);
		unr_s7   <= unr_q[CORDIC_LAT-1];
	end

	assign alpha = alpha_s7;
	assign beta  = $signed(beta_s7);
	assign unr   = unr_s7;

endmodule

FILE: rtl/five_bar_leg_inverse_kinematics_top.sv
`timescale 1ns / 1ps
// Top level: APB register file, two leg lanes and the output merge stage.
// Depends on fbik_pkg and fbik_leg.
//
// Takes one left/right foot target pair per clock: busy never rises, so start
// may be held high every cycle. Each request yields exactly one result, which
// passes through 5 coefficient stages, 29 square root stages, one numerator
// stage, 22 arctangent stages, lane select and the merge register. The result
// sits on the output ports for one cycle with done high; the receiver cannot
// stall it. Register writes take effect at once and must only happen with no
// request in flight.
module five_bar_leg_inverse_kinematics_top import fbik_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [POS_W-1:0] left_x,
	input  logic signed [POS_W-1:0] left_y,
	input  logic signed [POS_W-1:0] right_x,
	input  logic signed [POS_W-1:0] right_y,
	output logic                    done,
	output logic [OUT_W-1:0]        alpha_left,
	output logic signed [OUT_W-1:0] beta_left,
	output logic [OUT_W-1:0]        alpha_right,
	output logic signed [OUT_W-1:0] beta_right,
	output logic                    left_unreachable,
	output logic                    right_unreachable,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam logic [2:0] REG_CRANK_ONE = 3'd0;
	localparam logic [2:0] REG_ROD_ONE   = 3'd1;
	localparam logic [2:0] REG_ROD_TWO   = 3'd2;
	localparam logic [2:0] REG_CRANK_TWO = 3'd3;
	localparam logic [2:0] REG_SPACING   = 3'd4;
	localparam logic [2:0] REG_MIN_H     = 3'd5;
	localparam logic [2:0] REG_MAX_H     = 3'd6;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crank_one_length <= LEN_W'(1200);
			cfg_q.rod_one_length   <= LEN_W'(2400);
			cfg_q.rod_two_length   <= LEN_W'(2400);
			cfg_q.crank_two_length <= LEN_W'(1200);
			cfg_q.motor_spacing    <= LEN_W'(800);
			cfg_q.min_height       <= LEN_W'(1760);
			cfg_q.max_height       <= LEN_W'(4800);
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_CRANK_ONE: cfg_q.crank_one_length <= pwdata[LEN_W-1:0];
				REG_ROD_ONE:   cfg_q.rod_one_length   <= pwdata[LEN_W-1:0];
				REG_ROD_TWO:   cfg_q.rod_two_length   <= pwdata[LEN_W-1:0];
				REG_CRANK_TWO: cfg_q.crank_two_length <= pwdata[LEN_W-1:0];
				REG_SPACING:   cfg_q.motor_spacing    <= pwdata[LEN_W-1:0];
				REG_MIN_H:     cfg_q.min_height       <= pwdata[LEN_W-1:0];
				REG_MAX_H:     cfg_q.max_height       <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_CRANK_ONE: prdata = 32'(cfg_q.crank_one_length);
			REG_ROD_ONE:   prdata = 32'(cfg_q.rod_one_length);
			REG_ROD_TWO:   prdata = 32'(cfg_q.rod_two_length);
			REG_CRANK_TWO: prdata = 32'(cfg_q.crank_two_length);
			REG_SPACING:   prdata = 32'(cfg_q.motor_spacing);
			REG_MIN_H:     prdata = 32'(cfg_q.min_height);
			REG_MAX_H:     prdata = 32'(cfg_q.max_height);
			default:       prdata = '0;
		endcase
	end

	logic [TOP_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOP_LAT-2:0], start && !busy};
		end
	end

	logic [OUT_W-1:0]        al_l, al_r;
	logic signed [OUT_W-1:0] be_l, be_r;
	logic                    unr_l, unr_r;

	fbik_leg u_leg_left (
		.clk(clk), .x(left_x), .y(left_y), .cfg(cfg_q),
		.alpha(al_l), .beta(be_l), .unr(unr_l)
	);

	fbik_leg u_leg_right (
		.clk(clk), .x(right_x), .y(right_y), .cfg(cfg_q),
		.alpha(al_r), .beta(be_r), .unr(unr_r)
	);

	logic [OUT_W-1:0]        alpha_left_q, alpha_right_q;
	logic signed [OUT_W-1:0] beta_left_q, beta_right_q;
	logic                    unr_left_q, unr_right_q;

	always_ff @(posedge clk) begin
		alpha_left_q  <= al_l;
		beta_left_q   <= be_l;
		unr_left_q    <= unr_l;
		alpha_right_q <= al_r;
		beta_right_q  <= be_r;
		unr_right_q   <= unr_r;
	end

	assign done              = vld_q[TOP_LAT-1];
	assign alpha_left        = alpha_left_q;
	assign beta_left         = beta_left_q;
	assign left_unreachable  = unr_left_q;
	assign alpha_right       = alpha_right_q;
	assign beta_right        = beta_right_q;
	assign right_unreachable = unr_right_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(TOP_LAT) done)
		else $error("request did not produce a result at the pipeline depth");

	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOP_LAT))
		else $error("result without a matching request");

	a_left_unr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && left_unreachable) |-> (alpha_left == '0 && beta_left == '0))
		else $error("left unreachable with nonzero angles");

	a_right_unr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && right_unreachable) |-> (alpha_right == '0 && beta_right == '0))
		else $error("right unreachable with nonzero angles");

endmodule
